@@ hw/rtl/sorted_set_union_assert.svh @@
// ----------------------------------------------------------------------------
// Sorted set union: assertion macros
// Shared shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_UNION_ASSERT_SVH
`define SORTED_SET_UNION_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted
`define SSU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define SSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycles themselves
`define SSU_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ssu_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted set union: package
// Transaction payload types, command codes and result status codes.
// ----------------------------------------------------------------------------
package ssu_pkg;

    // Command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_ENTRY     = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;

    // Input transaction
    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
    } t_in;

    // Output transaction
    typedef struct packed {
        logic signed [31:0] element;
        logic [2:0]         status;
        logic               last;
    } t_out;

endpackage

@@ hw/rtl/sorted_set_union.sv @@
// ----------------------------------------------------------------------------
// Sorted set union: top level
// Sorted set of distinct signed 32-bit values kept in one synchronous memory.
// ----------------------------------------------------------------------------
// The set lives in a CAPACITY-deep single-port-write, one-read memory with a
// registered read; only the entry count sits in flops, so no clearing pass is
// needed after reset. Clear, code 3, a dump of an empty set and an insert into
// an empty set are handled straight from the idle state. An insert into a set
// of N entries walks the memory upward one entry per cycle, carrying displaced
// entries one slot up as it goes, and ends with a tail write of the last
// carried entry when one is left; it stops at the insertion point if the value
// is a duplicate or the set is full. A dump streams N results at one per cycle
// while the output side keeps up. A new command is taken whenever the sequencer
// is idle, even while the last result still waits in the output register.
// ----------------------------------------------------------------------------
module sorted_set_union #(
    parameter int CAPACITY = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ssu_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ssu_pkg::t_out   o_out_data
);
    import ssu_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_DUMP,
        S_POST
    } t_state;

    // Registers
    t_state             r_state,   n_state;
    logic [CW-1:0]      r_count,   n_count;
    logic [AW-1:0]      r_raddr,   n_raddr;
    logic signed [31:0] r_val,     n_val;
    logic signed [31:0] r_carry,   n_carry;
    logic               r_shift,   n_shift;
    t_out               r_pend,    n_pend;
    logic               r_ovalid;
    t_out               r_odata;

    // Memory and its ports
    logic signed [31:0] r_mem [CAPACITY];
    logic signed [31:0] r_rd_data;
    logic               we;
    logic [AW-1:0]      waddr;
    logic signed [31:0] wdata;

    // Control
    logic               in_acc;
    logic               out_free;
    logic               at_last;
    logic               is_full;
    logic               fin;
    t_out               fin_data;
    logic               res_ld;
    t_out               res_data;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_ovalid || i_out_ready;
    assign at_last     = (CW'(r_raddr) == (r_count - 1'b1));
    assign is_full     = (r_count == CW'(CAPACITY));
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // Sequence commands and compute next state
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_raddr  = '0;
        n_val    = r_val;
        n_carry  = r_carry;
        n_shift  = r_shift;
        n_pend   = r_pend;
        we       = 1'b0;
        waddr    = '0;
        wdata    = '0;
        fin      = 1'b0;
        fin_data = '0;
        res_ld   = 1'b0;
        res_data = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.command)
                        CMD_CLEAR: begin
                            n_count  = '0;
                            fin      = 1'b1;
                            fin_data = '{element: '0, status: ST_CLEARED, last: 1'b1};
                        end
                        CMD_INSERT: begin
                            n_val = i_in_data.value;
                            if (r_count == '0) begin
                                we       = 1'b1;
                                waddr    = '0;
                                wdata    = i_in_data.value;
                                n_count  = CW'(1);
                                fin      = 1'b1;
                                fin_data = '{element: i_in_data.value, status: ST_INSERTED,
                                             last: 1'b1};
                            end else begin
                                n_state = S_SCAN;
                                n_shift = 1'b0;
                            end
                        end
                        CMD_DUMP: begin
                            if (r_count == '0) begin
                                fin      = 1'b1;
                                fin_data = '{element: '0, status: ST_EMPTY, last: 1'b1};
                            end else begin
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            // drop unused command code
                        end
                    endcase
                end
            end

            S_SCAN: begin
                n_raddr = at_last ? '0 : r_raddr + 1'b1;
                if (!r_shift) begin
                    // search for the first entry not below the new value
                    if (r_rd_data == r_val) begin
                        fin      = 1'b1;
                        fin_data = '{element: r_val, status: ST_DUPLICATE, last: 1'b1};
                    end else if (r_rd_data < r_val) begin
                        if (at_last) begin
                            fin = 1'b1;
                            if (is_full) begin
                                fin_data = '{element: r_val, status: ST_FULL, last: 1'b1};
                            end else begin
                                we       = 1'b1;
                                waddr    = r_count[AW-1:0];
                                wdata    = r_val;
                                n_count  = r_count + 1'b1;
                                fin_data = '{element: r_val, status: ST_INSERTED,
                                             last: 1'b1};
                            end
                        end
                    end else if (is_full) begin
                        fin      = 1'b1;
                        fin_data = '{element: r_val, status: ST_FULL, last: 1'b1};
                    end else begin
                        // place the value and carry the displaced entry
                        we      = 1'b1;
                        waddr   = r_raddr;
                        wdata   = r_val;
                        n_carry = r_rd_data;
                        n_shift = 1'b1;
                        if (at_last) begin
                            n_state = S_TAIL;
                        end
                    end
                end else begin
                    // shift: write the carried entry, pick up the next one
                    we      = 1'b1;
                    waddr   = r_raddr;
                    wdata   = r_carry;
                    n_carry = r_rd_data;
                    if (at_last) begin
                        n_state = S_TAIL;
                    end
                end
            end

            S_TAIL: begin
                we       = 1'b1;
                waddr    = r_count[AW-1:0];
                wdata    = r_carry;
                n_count  = r_count + 1'b1;
                fin      = 1'b1;
                fin_data = '{element: r_val, status: ST_INSERTED, last: 1'b1};
            end

            S_DUMP: begin
                if (out_free) begin
                    res_ld   = 1'b1;
                    res_data = '{element: r_rd_data, status: ST_ENTRY, last: at_last};
                    if (at_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_raddr = r_raddr + 1'b1;
                    end
                end else begin
                    n_raddr = r_raddr;
                end
            end

            S_POST: begin
                if (out_free) begin
                    res_ld   = 1'b1;
                    res_data = r_pend;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Deliver a final result now, or park it until the output frees up
        if (fin) begin
            if (out_free) begin
                res_ld   = 1'b1;
                res_data = fin_data;
                n_state  = S_IDLE;
            end else begin
                n_pend  = fin_data;
                n_state = S_POST;
            end
        end
    end

    // Hold state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_shift  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_shift <= n_shift;
            if (res_ld) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
        r_raddr <= n_raddr;
        r_val   <= n_val;
        r_carry <= n_carry;
        r_pend  <= n_pend;
        if (res_ld) begin
            r_odata <= res_data;
        end
    end

    // Set memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_data <= r_mem[n_raddr];
    end

endmodule

@@ hw/rtl/ssu_checker.sv @@
// ----------------------------------------------------------------------------
// Sorted set union: port checker
// Watches the top level's ports and flags results that break the contract.
// ----------------------------------------------------------------------------
`include "sorted_set_union_assert.svh"

module ssu_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            o_in_ready,
    input  ssu_pkg::t_in    i_in_data,
    input  logic            o_out_valid,
    input  logic            i_out_ready,
    input  ssu_pkg::t_out   o_out_data
);
    import ssu_pkg::*;

    // A stalled output transaction holds
    `SSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "output transaction changed while stalled")

    // Only dump entries may leave the last flag low
    `SSU_ASSERT_IMPLY(a_single_last, i_clk, i_rst_n, o_out_valid && (o_out_data.status != ST_ENTRY), o_out_data.last, "single result without last flag")

    // Cleared and empty results carry a zero element
    `SSU_ASSERT_IMPLY(a_zero_elem, i_clk, i_rst_n, o_out_valid && ((o_out_data.status == ST_EMPTY) || (o_out_data.status == ST_CLEARED)), o_out_data.element == '0, "status result with nonzero element")

    // No output transaction straight out of reset
    `SSU_ASSERT_ALWAYS_NEXT(a_reset_quiet, i_clk, !i_rst_n, !o_out_valid, "output valid after reset")

endmodule

bind sorted_set_union ssu_checker u_ssu_checker (.*);

@@ dv/sorted_set_union_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set union: transaction checker
// Watches both channels of the block, keeps its own copy of the sorted set,
// predicts the results of every accepted command and compares each accepted
// result with the oldest prediction. Failures are counted and handed up.
// ----------------------------------------------------------------------------
module sorted_set_union_checker
    import ssu_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_ready,
    input  t_in   i_in_data,
    input  logic  i_out_valid,
    input  logic  i_out_ready,
    input  t_out  i_out_data,
    output int    o_fail_count,
    output int    o_pending
);

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the set, ascending, and its size
    logic signed [31:0] set_entries [CAPACITY];
    int                 set_size;

    // Results predicted but not yet seen on the output channel
    t_out               expected_results [$];

    initial begin
        set_size     = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void log_failure(input string text);
        if (o_fail_count < REPORT_LIMIT) begin
            $display("%0t: mismatch: %s", $realtime, text);
        end
        o_fail_count++;
    endfunction

    // Apply one command to the shadow set and queue the results it causes
    function automatic void predict_results(input t_in cmd_item);
        int                 pos;
        logic signed [31:0] v;
        v = cmd_item.value;
        case (cmd_item.command)
            CMD_CLEAR: begin
                set_size = 0;
                expected_results.push_back('{element: '0, status: ST_CLEARED, last: 1'b1});
            end
            CMD_INSERT: begin
                pos = 0;
                while (pos < set_size && set_entries[pos] < v) begin
                    pos++;
                end
                if (pos < set_size && set_entries[pos] == v) begin
                    expected_results.push_back('{element: v, status: ST_DUPLICATE, last: 1'b1});
                end else if (set_size >= CAPACITY) begin
                    expected_results.push_back('{element: v, status: ST_FULL, last: 1'b1});
                end else begin
                    for (int i = set_size; i > pos; i--) begin
                        set_entries[i] = set_entries[i - 1];
                    end
                    set_entries[pos] = v;
                    set_size++;
                    expected_results.push_back('{element: v, status: ST_INSERTED, last: 1'b1});
                end
            end
            CMD_DUMP: begin
                if (set_size == 0) begin
                    expected_results.push_back('{element: '0, status: ST_EMPTY, last: 1'b1});
                end else begin
                    for (int i = 0; i < set_size; i++) begin
                        expected_results.push_back('{element: set_entries[i], status: ST_ENTRY,
                                                     last: (i == set_size - 1)});
                    end
                end
            end
            default: begin
                // unused code: no result, no state change
            end
        endcase
    endfunction

    // Sample both channels at the edge; predict first, then compare
    always @(posedge i_clk) begin : monitor
        t_out want;
        t_out got;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                predict_results(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_results.size() == 0) begin
                    log_failure($sformatf("unexpected result element=%0d status=%0d last=%0b",
                                          got.element, got.status, got.last));
                end else begin
                    want = expected_results.pop_front();
                    if (got.element !== want.element || got.status !== want.status
                            || got.last !== want.last) begin
                        log_failure($sformatf({"expected element=%0d status=%0d last=%0b, ",
                                               "got element=%0d status=%0d last=%0b"},
                                              want.element, want.status, want.last,
                                              got.element, got.status, got.last));
                    end
                end
            end
            o_pending = expected_results.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set union: testbench top
// Drives clear, insert and dump commands into the block: a directed opening
// on extreme values, duplicates and the unused code, then random union
// sequences (clear, two lists, dump) mixed with noise, over four phases of
// sender gaps and receiver stalls. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import ssu_pkg::*;

    localparam int         CAPACITY     = 32;
    localparam int         CYCLE_LIMIT  = 400_000;
    localparam int         DRAIN_CYCLES = CAPACITY + 16;
    localparam int         PHASE_ITEMS  = 100;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    t_in   in_data   = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    t_out  out_data;

    int    fail_count;
    int    pending;
    int    cycle_count   = 0;
    int    send_idle_pct = 0;
    int    stall_pct     = 0;
    int    items_sent    = 0;

    // Clock: 8 ns period
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sorted_set_union #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    sorted_set_union_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stall the result channel at the current rate
    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[sorted_set_union] ERROR");
            $finish;
        end
    end

    // Present one command and hold it until the transaction completes
    task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{command: cmd, value: val};
        do @(posedge clk); while (!in_ready);
        if (cmd != CMD_UNUSED) begin
            items_sent++;
        end
    endtask

    // Value source: narrow range for collisions, full range, or extremes
    function automatic logic signed [31:0] pick_value(input int mode);
        logic signed [31:0] v;
        case (mode)
            0:       v = $signed($urandom_range(0, 16)) - 32'sd8;
            1:       v = $urandom;
            default: begin
                case ($urandom_range(0, 5))
                    0:       v = VAL_MIN;
                    1:       v = VAL_MAX;
                    2:       v = VAL_MIN + 32'sd1;
                    3:       v = VAL_MAX - 32'sd1;
                    4:       v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            end
        endcase
        return v;
    endfunction

    // Run union sequences, with some noise, until the phase's item count is reached
    task automatic run_phase(input int idle_pct, input int stall);
        int                 target;
        int                 seq_idx;
        int                 mode;
        int                 len_a;
        int                 len_b;
        logic signed [31:0] list_a [$];
        logic signed [31:0] v;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        target        = items_sent + PHASE_ITEMS;
        seq_idx       = 0;
        while (items_sent < target) begin
            seq_idx++;
            if ($urandom_range(0, 99) < 8) begin
                // noise: any code, any value
                send_item(2'($urandom_range(0, 3)), $urandom);
            end else begin
                list_a.delete();
                // long sequences overflow the set to reach the full case
                if (seq_idx % 6 == 0) begin
                    mode  = 1;
                    len_a = $urandom_range(24, 30);
                    len_b = $urandom_range(12, 16);
                end else begin
                    mode  = $urandom_range(0, 2);
                    len_a = $urandom_range(1, 8);
                    len_b = $urandom_range(0, 8);
                end
                // skip the clear now and then to carry old contents over
                if ($urandom_range(0, 99) >= 10) begin
                    send_item(CMD_CLEAR, $urandom);
                end
                for (int i = 0; i < len_a; i++) begin
                    v = pick_value(mode);
                    list_a.push_back(v);
                    send_item(CMD_INSERT, v);
                end
                if ($urandom_range(0, 99) < 15) begin
                    send_item(CMD_DUMP, $urandom);
                end
                for (int i = 0; i < len_b; i++) begin
                    if ($urandom_range(0, 99) < 30) begin
                        v = list_a[$urandom_range(0, list_a.size() - 1)];
                    end else begin
                        v = pick_value(mode);
                    end
                    send_item(CMD_INSERT, v);
                end
                send_item(CMD_DUMP, $urandom);
            end
        end
    endtask

    initial begin
        // Hold reset low, then release it
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: empty dump, extremes, duplicates, unused code
        send_item(CMD_DUMP,   32'sd0);
        send_item(CMD_INSERT, 32'sd0);
        send_item(CMD_INSERT, VAL_MAX);
        send_item(CMD_INSERT, VAL_MIN);
        send_item(CMD_INSERT, -32'sd1);
        send_item(CMD_INSERT, 32'sd1);
        send_item(CMD_INSERT, 32'sd0);
        send_item(CMD_INSERT, VAL_MIN);
        send_item(CMD_INSERT, VAL_MAX);
        send_item(CMD_DUMP,   -32'sd1);
        send_item(CMD_UNUSED, -32'sd1);
        send_item(CMD_DUMP,   32'sd0);
        send_item(CMD_CLEAR,  -32'sd1);
        send_item(CMD_DUMP,   VAL_MAX);
        send_item(CMD_INSERT, 32'sh5555_5555);
        send_item(CMD_INSERT, 32'shAAAA_AAAA);
        send_item(CMD_INSERT, 32'sh5555_5555);
        send_item(CMD_DUMP,   32'sd0);
        send_item(CMD_UNUSED, 32'sd0);
        send_item(CMD_CLEAR,  32'sd0);
        send_item(CMD_INSERT, VAL_MIN);
        send_item(CMD_DUMP,   32'sd0);

        // Random part over the four flow-control phases
        run_phase(0, 0);
        run_phase(57, 0);
        run_phase(0, 57);
        run_phase(35, 35);
        in_valid <= 1'b0;

        // Let the checker record the final transaction, then drain and watch for strays
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("[sorted_set_union] OK");
        end else begin
            $display("[sorted_set_union] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ssu_pkg.sv
hw/rtl/sorted_set_union.sv
hw/rtl/ssu_checker.sv
dv/sorted_set_union_checker.sv
dv/testbench.sv
